// ----- hdl/pgog_pkg.sv -----
// Shared package for the premultiplied gain/offset/gamma grade block.
// Holds widths, register indexes, pipeline latencies, side-band structs
// and the constant root table used by the pipelined exp2 unit. No dependencies.
package pgog_pkg;

  localparam int COLOR_W   = 24;
  localparam int ALPHA_W   = 17;
  localparam int GO_W      = 32;
  localparam int GAM_W     = 23;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int GLIN_W    = 23;   // graded linear value, non-negative

  localparam int FRAC_BITS  = 16;  // colour fraction bits
  localparam int OFF_SHIFT  = FRAC_BITS - 11;

  localparam logic signed [COLOR_W-1:0] COLOR_MAX = 24'sh7F_FFFF;
  localparam logic signed [COLOR_W-1:0] COLOR_MIN = -24'sh80_0000;
  localparam logic [ALPHA_W-1:0] ALPHA_MIN_EXCL = 17'd6;
  localparam logic signed [24:0] GAMMA_TOL = 25'sd65;
  localparam logic signed [24:0] ONE_Q16   = 25'sd65536;

  localparam logic [GO_W-1:0]  GO_RESET  = 32'h1000_0000;
  localparam logic [GAM_W-1:0] GAM_RESET = 23'd65536;

  // Divider: one setup stage, then DIV_BITS quotient bits per stage
  localparam int DIV_QBITS = 24;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = DIV_QBITS / DIV_BITS;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  localparam int LOG_ITERS = 16;
  localparam int LOG_LAT   = LOG_ITERS + 1;
  localparam int POW_ITERS = 16;
  localparam int POW_LAT   = POW_ITERS + 2;

  // Stage numbers inside one channel
  localparam int G_STG    = DIV_LAT + 3;               // graded value registered
  localparam int POW_OUT  = G_STG + LOG_LAT + 1 + POW_LAT;
  localparam int CHAN_LAT = POW_OUT + 2;
  localparam int GL_LEN   = POW_OUT - G_STG + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GO_RED    = 3'd0,
    CFG_GO_GREEN  = 3'd1,
    CFG_GO_BLUE   = 3'd2,
    CFG_GAM_RED   = 3'd3,
    CFG_GAM_GREEN = 3'd4,
    CFG_GAM_BLUE  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COLOR_W-1:0] c;
    logic [ALPHA_W-1:0]        a;
    logic                      neg;
    logic                      byp;
  } side_t;

  typedef struct packed {
    logic [GLIN_W-1:0] g;
    logic              on;
  } gam_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    rem = v;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bt) begin
        rem = rem - res - bt;
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(2^-i) in Q1.30, built by repeated truncated square roots of 2.0
  function automatic logic [31:0] root_q30(input int i);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int j = 0; j < POW_ITERS; j++) begin
      if (j < i) r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

endpackage

// ----- hdl/premultiplied_gain_offset_gamma_grade.sv -----
// Top level of the premultiplied gain/offset/gamma colour grade.
// Instantiates three pgog_chan lanes; uses pgog_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one premultiplied RGBA request
//   per cycle when ready: signed Q8.16 colour, Q1.16 alpha. Output channel
//   (out_valid/out_ready) returns one graded request per input, in order.
//   Alpha at or below 6 passes the colours unchanged; alpha always passes.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0..2 gain/offset per channel, 3..5 inverse gamma). Write only while
//   the pipeline is empty; registers are read live, not sampled on entry.
// Timing:
//   A request passes a 7-stage divider, gain and offset, a 17-stage log2,
//   one exponent multiply, an 18-stage exp2 and the premultiply.
//   Throughput is one request per cycle while the output is not stalled.
// Reset:
//   Synchronous, active low. Valid bits clear and registers take unity
//   gain, zero offset and unity inverse gamma.
// Stall:
//   When the output holds a request that is not taken, the whole pipeline
//   holds and in_ready drops in the same cycle; nothing is dropped.
module premultiplied_gain_offset_gamma_grade (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pgog_pkg::COLOR_W-1:0]   in_red_in,
  input  logic signed [pgog_pkg::COLOR_W-1:0]   in_green_in,
  input  logic signed [pgog_pkg::COLOR_W-1:0]   in_blue_in,
  input  logic [pgog_pkg::ALPHA_W-1:0]          in_alpha_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pgog_pkg::COLOR_W-1:0]   out_red_out,
  output logic signed [pgog_pkg::COLOR_W-1:0]   out_green_out,
  output logic signed [pgog_pkg::COLOR_W-1:0]   out_blue_out,
  output logic [pgog_pkg::ALPHA_W-1:0]          out_alpha_out,
  input  logic                                  cfg_we,
  input  logic [pgog_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pgog_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int L = pgog_pkg::CHAN_LAT;

  logic [pgog_pkg::GO_W-1:0]  go_r  [3];
  logic [pgog_pkg::GAM_W-1:0] gam_r [3];

  // Hold configuration; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        go_r[i]  <= pgog_pkg::GO_RESET;
        gam_r[i] <= pgog_pkg::GAM_RESET;
      end
    end else if (cfg_we) begin
      case (pgog_pkg::cfg_idx_t'(cfg_index))
        pgog_pkg::CFG_GO_RED:    go_r[0]  <= cfg_wdata;
        pgog_pkg::CFG_GO_GREEN:  go_r[1]  <= cfg_wdata;
        pgog_pkg::CFG_GO_BLUE:   go_r[2]  <= cfg_wdata;
        pgog_pkg::CFG_GAM_RED:   gam_r[0] <= cfg_wdata[pgog_pkg::GAM_W-1:0];
        pgog_pkg::CFG_GAM_GREEN: gam_r[1] <= cfg_wdata[pgog_pkg::GAM_W-1:0];
        pgog_pkg::CFG_GAM_BLUE:  gam_r[2] <= cfg_wdata[pgog_pkg::GAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance every stage together unless the output request is stuck
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic                         vl_r [L];
  logic [pgog_pkg::ALPHA_W-1:0] al_r [L];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < L; s++) vl_r[s] <= 1'b0;
    end else if (adv) begin
      vl_r[0] <= in_valid;
      for (int s = 1; s < L; s++) vl_r[s] <= vl_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      al_r[0] <= in_alpha_in;
      for (int s = 1; s < L; s++) al_r[s] <= al_r[s-1];
    end
  end

  pgog_chan u_red (
    .clk (clk), .adv (adv), .c (in_red_in), .a (in_alpha_in),
    .go (go_r[0]), .inv (gam_r[0]), .o (out_red_out)
  );

  pgog_chan u_green (
    .clk (clk), .adv (adv), .c (in_green_in), .a (in_alpha_in),
    .go (go_r[1]), .inv (gam_r[1]), .o (out_green_out)
  );

  pgog_chan u_blue (
    .clk (clk), .adv (adv), .c (in_blue_in), .a (in_alpha_in),
    .go (go_r[2]), .inv (gam_r[2]), .o (out_blue_out)
  );

  assign out_valid     = vl_r[L-1];
  assign out_alpha_out = al_r[L-1];

endmodule

// ----- hdl/pgog_div.sv -----
// Pipelined restoring divider: |c| * 2^16 / alpha with overflow flag.
// Uses pgog_pkg for widths and stage counts.
module pgog_div (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [pgog_pkg::COLOR_W-1:0]  num,
  input  logic [pgog_pkg::ALPHA_W-1:0]  den,
  output logic [pgog_pkg::DIV_QBITS-1:0] quo,
  output logic                          ovf
);

  localparam int N = pgog_pkg::DIV_LAT;
  localparam int AW = pgog_pkg::ALPHA_W;

  logic [AW-1:0]                  rem_r [N];
  logic [pgog_pkg::DIV_QBITS-1:0] low_r [N];
  logic [pgog_pkg::DIV_QBITS-1:0] q_r   [N];
  logic [AW-1:0]                  den_r [N];
  logic                           ovf_r [N];

  // Setup: quotient above 24 bits is flagged, remainder seeded with high part
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= {1'b0, num[23:8]};
      low_r[0] <= {num[7:0], 16'h0000};
      q_r[0]   <= '0;
      den_r[0] <= den;
      ovf_r[0] <= ({1'b0, num[23:8]} >= den);
    end
  end

  for (genvar s = 1; s < N; s++) begin : g_stage
    logic [AW-1:0]                  rem_nxt;
    logic [pgog_pkg::DIV_QBITS-1:0] low_nxt;
    logic [pgog_pkg::DIV_QBITS-1:0] q_nxt;
    logic [AW:0]                    trial;

    always_comb begin
      rem_nxt = rem_r[s-1];
      low_nxt = low_r[s-1];
      q_nxt   = q_r[s-1];
      trial   = '0;
      for (int j = 0; j < pgog_pkg::DIV_BITS; j++) begin
        trial   = {rem_nxt, low_nxt[pgog_pkg::DIV_QBITS-1]};
        low_nxt = {low_nxt[pgog_pkg::DIV_QBITS-2:0], 1'b0};
        if (trial >= {1'b0, den_r[s-1]}) begin
          trial   = trial - {1'b0, den_r[s-1]};
          q_nxt   = {q_nxt[pgog_pkg::DIV_QBITS-2:0], 1'b1};
        end else begin
          q_nxt   = {q_nxt[pgog_pkg::DIV_QBITS-2:0], 1'b0};
        end
        rem_nxt = trial[AW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= rem_nxt;
        low_r[s] <= low_nxt;
        q_r[s]   <= q_nxt;
        den_r[s] <= den_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  assign quo = q_r[N-1];
  assign ovf = ovf_r[N-1];

endmodule

// ----- hdl/pgog_log.sv -----
// Pipelined log2 in Q.16: leading-one search, then one squaring per stage.
// Uses pgog_pkg for widths and the iteration count.
module pgog_log (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [pgog_pkg::GLIN_W-1:0]  g,
  output logic signed [21:0]           lg
);

  localparam int N = pgog_pkg::LOG_LAT;
  localparam logic signed [5:0] FB = 6'(pgog_pkg::FRAC_BITS);

  logic [30:0] m_r  [N];
  logic [15:0] fr_r [N];
  logic [4:0]  p_r  [N];

  logic [4:0]  p_nxt;
  logic [30:0] m_nxt;

  always_comb begin
    p_nxt = '0;
    for (int b = 0; b < pgog_pkg::GLIN_W; b++) begin
      if (g[b]) p_nxt = 5'(b);
    end
    m_nxt = 31'(g) << (5'd30 - p_nxt);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0]  <= m_nxt;
      fr_r[0] <= '0;
      p_r[0]  <= p_nxt;
    end
  end

  for (genvar i = 1; i < N; i++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = 62'(m_r[i-1]) * 62'(m_r[i-1]);
    assign t  = sq[61:30];

    // renormalize to [1,2) and shift the carry out into the fraction
    always_ff @(posedge clk) begin
      if (adv) begin
        if (t[31]) begin
          m_r[i]  <= t[31:1];
          fr_r[i] <= {fr_r[i-1][14:0], 1'b1};
        end else begin
          m_r[i]  <= t[30:0];
          fr_r[i] <= {fr_r[i-1][14:0], 1'b0};
        end
        p_r[i] <= p_r[i-1];
      end
    end
  end

  logic signed [5:0] ip;
  assign ip = $signed({1'b0, p_r[N-1]}) - FB;
  assign lg = {ip, fr_r[N-1]};

endmodule

// ----- hdl/pgog_pow.sv -----
// Pipelined exp2: one constant root multiply per fraction bit, final shift.
// Uses pgog_pkg for the root table, widths and saturation limit.
module pgog_pow (
  input  logic                        clk,
  input  logic                        adv,
  input  logic signed [29:0]          e,
  output logic [pgog_pkg::GLIN_W-1:0] h
);

  localparam int N = pgog_pkg::POW_ITERS + 1;
  localparam logic signed [14:0] SH_BASE = 15'(30 - pgog_pkg::FRAC_BITS);
  localparam logic signed [13:0] K_SAT   = 14'(23 - pgog_pkg::FRAC_BITS);

  logic [31:0] acc_r [N];
  logic [15:0] f_r   [N];
  logic [4:0]  sh_r  [N];
  logic        sat_r [N];
  logic        zro_r [N];
  logic [pgog_pkg::GLIN_W-1:0] h_r;

  logic signed [13:0] k;
  logic signed [14:0] sh_w;
  assign k    = e[29:16];
  assign sh_w = SH_BASE - 15'(k);

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r[0] <= 32'h4000_0000;
      f_r[0]   <= e[15:0];
      sh_r[0]  <= sh_w[4:0];
      sat_r[0] <= (k >= K_SAT);
      zro_r[0] <= (sh_w > 15'sd30);
    end
  end

  for (genvar i = 1; i < N; i++) begin : g_mul
    localparam logic [31:0] RC = pgog_pkg::root_q30(i);
    logic [63:0] pr;
    assign pr = 64'(acc_r[i-1]) * 64'(RC);

    always_ff @(posedge clk) begin
      if (adv) begin
        acc_r[i] <= f_r[i-1][16-i] ? pr[61:30] : acc_r[i-1];
        f_r[i]   <= f_r[i-1];
        sh_r[i]  <= sh_r[i-1];
        sat_r[i] <= sat_r[i-1];
        zro_r[i] <= zro_r[i-1];
      end
    end
  end

  logic [31:0] shifted;
  assign shifted = acc_r[N-1] >> sh_r[N-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sat_r[N-1])      h_r <= pgog_pkg::COLOR_MAX[22:0];
      else if (zro_r[N-1]) h_r <= '0;
      else                 h_r <= shifted[22:0];
    end
  end

  assign h = h_r;

endmodule

// ----- hdl/pgog_chan.sv -----
// One colour channel: unpremultiply, gain/offset, gamma, premultiply.
// Instantiates pgog_div, pgog_log and pgog_pow; uses pgog_pkg.
module pgog_chan (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [pgog_pkg::COLOR_W-1:0] c,
  input  logic [pgog_pkg::ALPHA_W-1:0]        a,
  input  logic [pgog_pkg::GO_W-1:0]           go,
  input  logic [pgog_pkg::GAM_W-1:0]          inv,
  output logic signed [pgog_pkg::COLOR_W-1:0] o
);

  localparam int SL = pgog_pkg::CHAN_LAT - 1;

  pgog_pkg::side_t side_r [SL];
  pgog_pkg::gam_t  gl_r   [pgog_pkg::GL_LEN];

  logic [pgog_pkg::COLOR_W-1:0] mag;
  assign mag = c[23] ? (~c + 24'd1) : c;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{c: c, a: a, neg: c[23], byp: (a <= pgog_pkg::ALPHA_MIN_EXCL)};
      for (int s = 1; s < SL; s++) side_r[s] <= side_r[s-1];
    end
  end

  logic [23:0] quo;
  logic        ovf;

  pgog_div u_div (
    .clk (clk), .adv (adv), .num (mag), .den (a), .quo (quo), .ovf (ovf)
  );

  // unpremultiplied value, saturated, truncated toward zero
  logic signed [23:0] u_r;
  logic               neg_q;
  assign neg_q = side_r[pgog_pkg::DIV_LAT-1].neg;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!neg_q) u_r <= (ovf || quo[23]) ? pgog_pkg::COLOR_MAX : $signed(quo);
      else if (ovf || quo > 24'h80_0000) u_r <= pgog_pkg::COLOR_MIN;
      else u_r <= $signed(~quo + 24'd1);
    end
  end

  logic signed [40:0] gp_r;
  always_ff @(posedge clk) begin
    if (adv) gp_r <= u_r * $signed({1'b0, go[31:16]});
  end

  logic signed [41:0] sum;
  logic signed [24:0] dgam;
  logic [22:0]        g_nxt;

  always_comb begin
    sum  = 42'(gp_r >>> 12) + (42'($signed(go[15:0])) <<< pgog_pkg::OFF_SHIFT);
    if (sum < 42'sd0) g_nxt = '0;
    else if (sum > 42'(pgog_pkg::COLOR_MAX)) g_nxt = pgog_pkg::COLOR_MAX[22:0];
    else g_nxt = sum[22:0];
    dgam = $signed({2'b00, inv}) - pgog_pkg::ONE_Q16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gl_r[0].g  <= g_nxt;
      gl_r[0].on <= ((dgam > pgog_pkg::GAMMA_TOL) || (dgam < -pgog_pkg::GAMMA_TOL))
                    && (g_nxt != '0);
      for (int s = 1; s < pgog_pkg::GL_LEN; s++) gl_r[s] <= gl_r[s-1];
    end
  end

  logic signed [21:0] lg;
  pgog_log u_log (.clk (clk), .adv (adv), .g (gl_r[0].g), .lg (lg));

  logic signed [45:0] ep_r;
  always_ff @(posedge clk) begin
    if (adv) ep_r <= lg * $signed({1'b0, inv});
  end

  logic [22:0] ph;
  pgog_pow u_pow (.clk (clk), .adv (adv), .e (ep_r[45:16]), .h (ph));

  logic [22:0] hsel;
  logic [39:0] hp_r;
  logic signed [23:0] o_r;
  assign hsel = gl_r[pgog_pkg::GL_LEN-1].on ? ph : gl_r[pgog_pkg::GL_LEN-1].g;

  always_ff @(posedge clk) begin
    if (adv) begin
      hp_r <= 40'(hsel) * 40'(side_r[SL-2].a);
      if (side_r[SL-1].byp) o_r <= side_r[SL-1].c;
      else if (hp_r[39])    o_r <= pgog_pkg::COLOR_MAX;
      else                  o_r <= $signed({1'b0, hp_r[38:16]});
    end
  end

  assign o = o_r;

endmodule

// ----- hdl/pgog_checker.sv -----
// Port-level checker for the colour grade top level, with its bind.
// Sees only top-level ports; no package dependency.
module pgog_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_red_out,
  input logic [16:0] out_alpha_out
);

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red_out) && $stable(out_alpha_out))
    else $error("output payload changed while stalled");

endmodule

bind premultiplied_gain_offset_gamma_grade pgog_checker u_pgog_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_red_out   (out_red_out),
  .out_alpha_out (out_alpha_out)
);
